### hw/rtl/rectangle_canvas_rasterizer_unit_defines.svh
// ----------------------------------------------------------------------------
// rectangle canvas rasterizer assertion macros
// shared check forms used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef RECTANGLE_CANVAS_RASTERIZER_UNIT_DEFINES_SVH
`define RECTANGLE_CANVAS_RASTERIZER_UNIT_DEFINES_SVH

// same-cycle implication
`define RCR_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rcr check failed");

// next-cycle implication
`define RCR_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rcr check failed");

`endif

### hw/rtl/rcr_pkg.sv
// ----------------------------------------------------------------------------
// rcr_pkg
// widths, codes and helpers shared by the canvas rasterizer modules
// ----------------------------------------------------------------------------
package rcr_pkg;

  localparam int MAX_DIM   = 256;
  localparam int FRAC_BITS = 8;

  localparam int POS_W   = 24;
  localparam int SIZE_W  = 23;
  localparam int CFG_W   = 9;
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int ADDR_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int COORD_W = (POS_W + 2 > IDX_W + FRAC_BITS + 2) ?
                           (POS_W + 2) : (IDX_W + FRAC_BITS + 2);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [DIM_W-1:0]          dim_t;

  localparam coord_t ONE = coord_t'(1 << FRAC_BITS);

  typedef struct packed {
    logic in_span;
    logic edge_hit;
  } span_t;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_DRAW  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_ERR   = 2'd1;
  localparam logic [1:0] STS_RANGE = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BG     = 2'd2;

  localparam logic [CFG_W-1:0]  DIM_RESET = CFG_W'(256);
  localparam logic [BYTE_W-1:0] BG_RESET  = BYTE_W'(32);

  function automatic dim_t eff_dim(input logic [CFG_W-1:0] v);
    dim_t d;
    if (v == '0) begin
      d = dim_t'(1);
    end else if (32'(v) > MAX_DIM) begin
      d = dim_t'(MAX_DIM);
    end else begin
      d = dim_t'(v);
    end
    return d;
  endfunction

endpackage

### hw/rtl/rcr_ram.sv
// ----------------------------------------------------------------------------
// rcr_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module rcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/rcr_span_unit.sv
// ----------------------------------------------------------------------------
// rcr_span_unit
// shared span test: is a coordinate within [lo, hi] and within one unit
// of either end
// ----------------------------------------------------------------------------
module rcr_span_unit (
  input  rcr_pkg::coord_t coord,
  input  rcr_pkg::coord_t lo,
  input  rcr_pkg::coord_t hi,
  output rcr_pkg::span_t  result
);

  rcr_pkg::coord_t d_lo;
  rcr_pkg::coord_t d_hi;

  assign d_lo = coord - lo;
  assign d_hi = hi - coord;

  assign result.in_span  = !d_lo[rcr_pkg::COORD_W-1] && !d_hi[rcr_pkg::COORD_W-1];
  assign result.edge_hit = (d_lo < rcr_pkg::ONE) || (d_hi < rcr_pkg::ONE);

endmodule

### hw/rtl/rectangle_canvas_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// rectangle_canvas_rasterizer_unit
// character canvas with clear, rectangle draw and pixel read operations
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_ready) takes one operation per transfer; out
//   channel (out_valid/out_ready) returns exactly one result per operation.
//   cfg channel (cfg_valid/cfg_ready) writes canvas_width, canvas_height and
//   background_byte; write it only while no operation is in flight.
// operation flow:
//   a clear or valid draw sweeps the canvas: a row state runs the row span
//   test at the start of each row, then a pixel state visits each pixel of
//   that row; a read, an ignored draw or an unused code goes straight to the
//   final state. the sweep speed is set by the single span test unit and the
//   one canvas write port. one operation is in work at a time; in_ready is
//   high when the sequencer is idle, even while the previous result waits.
// reset:
//   registers return to 256 x 256 and a space background, the error flag
//   clears; canvas contents stay undefined until the first clear.
// stalls:
//   a held result keeps the next operation in its final state until the
//   output register is taken.
// ----------------------------------------------------------------------------
`include "rectangle_canvas_rasterizer_unit_defines.svh"

module rectangle_canvas_rasterizer_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        func,
  input  logic signed [rcr_pkg::POS_W-1:0]  rect_left,
  input  logic signed [rcr_pkg::POS_W-1:0]  rect_top,
  input  logic [rcr_pkg::SIZE_W-1:0]        rect_width,
  input  logic [rcr_pkg::SIZE_W-1:0]        rect_height,
  input  logic                              filled,
  input  logic [rcr_pkg::BYTE_W-1:0]        paint_byte,
  input  logic [7:0]                        pixel_col,
  input  logic [7:0]                        pixel_row,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rcr_pkg::BYTE_W-1:0]        pixel_value,
  output logic [1:0]                        status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [rcr_pkg::CFG_W-1:0]         cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ROW  = 2'd1;
  localparam logic [1:0] S_PIX  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state;

  logic [rcr_pkg::CFG_W-1:0]  canvas_width;
  logic [rcr_pkg::CFG_W-1:0]  canvas_height;
  logic [rcr_pkg::BYTE_W-1:0] background_byte;
  logic                       err;

  rcr_pkg::dim_t eff_w;
  rcr_pkg::dim_t eff_h;

  rcr_pkg::coord_t x_lo;
  rcr_pkg::coord_t x_hi;
  rcr_pkg::coord_t y_lo;
  rcr_pkg::coord_t y_hi;
  logic                       fill;
  logic                       is_clear;
  logic [rcr_pkg::BYTE_W-1:0] paint;

  logic [rcr_pkg::IDX_W-1:0]  col;
  logic [rcr_pkg::IDX_W-1:0]  row;
  logic [rcr_pkg::ADDR_W-1:0] row_base;
  logic                       row_in;
  logic                       row_edge;

  logic [1:0] res_status;
  logic       res_ram;

  rcr_pkg::coord_t span_coord;
  rcr_pkg::coord_t span_lo;
  rcr_pkg::coord_t span_hi;
  rcr_pkg::span_t  span;

  logic                       in_xfer;
  logic                       rd_inside;
  logic                       out_free;
  logic                       col_last;
  logic                       row_last;
  logic                       ram_we;
  logic [rcr_pkg::ADDR_W-1:0] ram_waddr;
  logic [rcr_pkg::BYTE_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [rcr_pkg::ADDR_W-1:0] ram_raddr;
  logic [rcr_pkg::BYTE_W-1:0] ram_rdata;

  logic                       draw_zero;
  logic                       clear_xfer;
  logic                       wr_in_canvas;

  assign eff_w = rcr_pkg::eff_dim(canvas_width);
  assign eff_h = rcr_pkg::eff_dim(canvas_height);

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  assign rd_inside = (32'(pixel_col) < 32'(eff_w)) && (32'(pixel_row) < 32'(eff_h));
  assign col_last  = (rcr_pkg::DIM_W'(col) == eff_w - rcr_pkg::DIM_W'(1));
  assign row_last  = (rcr_pkg::DIM_W'(row) == eff_h - rcr_pkg::DIM_W'(1));

  // shared span test: row pass at the start of each row, column pass per pixel
  always_comb begin
    if (state == S_ROW) begin
      span_coord = rcr_pkg::coord_t'(rcr_pkg::COORD_W'(row) << rcr_pkg::FRAC_BITS);
      span_lo    = y_lo;
      span_hi    = y_hi;
    end else begin
      span_coord = rcr_pkg::coord_t'(rcr_pkg::COORD_W'(col) << rcr_pkg::FRAC_BITS);
      span_lo    = x_lo;
      span_hi    = x_hi;
    end
  end

  rcr_span_unit u_span (
    .coord  (span_coord),
    .lo     (span_lo),
    .hi     (span_hi),
    .result (span)
  );

  assign ram_we    = (state == S_PIX) &&
                     (is_clear || (row_in && span.in_span && (fill || row_edge || span.edge_hit)));
  assign ram_waddr = row_base + rcr_pkg::ADDR_W'(col);
  assign ram_wdata = is_clear ? background_byte : paint;
  assign ram_re    = in_xfer && (func == rcr_pkg::FUNC_READ) && rd_inside;
  assign ram_raddr = rcr_pkg::ADDR_W'(rcr_pkg::ADDR_W'(pixel_row) *
                     rcr_pkg::ADDR_W'(rcr_pkg::MAX_DIM)) + rcr_pkg::ADDR_W'(pixel_col);

  rcr_ram #(
    .WIDTH (rcr_pkg::BYTE_W),
    .DEPTH (rcr_pkg::DEPTH)
  ) u_canvas (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= rcr_pkg::DIM_RESET;
      canvas_height   <= rcr_pkg::DIM_RESET;
      background_byte <= rcr_pkg::BG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rcr_pkg::CFG_WIDTH:  canvas_width    <= cfg_data;
        rcr_pkg::CFG_HEIGHT: canvas_height   <= cfg_data;
        rcr_pkg::CFG_BG:     background_byte <= cfg_data[rcr_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      err       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            col      <= '0;
            row      <= '0;
            row_base <= '0;
            res_ram  <= 1'b0;
            unique case (func)
              rcr_pkg::FUNC_CLEAR: begin
                err        <= 1'b0;
                is_clear   <= 1'b1;
                res_status <= rcr_pkg::STS_OK;
                state      <= S_ROW;
              end
              rcr_pkg::FUNC_DRAW: begin
                if (err || rect_width == '0 || rect_height == '0) begin
                  err        <= 1'b1;
                  res_status <= rcr_pkg::STS_ERR;
                  state      <= S_FIN;
                end else begin
                  is_clear   <= 1'b0;
                  fill       <= filled;
                  paint      <= paint_byte;
                  x_lo       <= rcr_pkg::coord_t'(rect_left);
                  y_lo       <= rcr_pkg::coord_t'(rect_top);
                  x_hi       <= rcr_pkg::coord_t'(rect_left) +
                                rcr_pkg::coord_t'({1'b0, rect_width});
                  y_hi       <= rcr_pkg::coord_t'(rect_top) +
                                rcr_pkg::coord_t'({1'b0, rect_height});
                  res_status <= rcr_pkg::STS_OK;
                  state      <= S_ROW;
                end
              end
              rcr_pkg::FUNC_READ: begin
                if (rd_inside) begin
                  res_ram    <= 1'b1;
                  res_status <= err ? rcr_pkg::STS_ERR : rcr_pkg::STS_OK;
                end else begin
                  res_status <= rcr_pkg::STS_RANGE;
                end
                state <= S_FIN;
              end
              default: begin
                res_status <= err ? rcr_pkg::STS_ERR : rcr_pkg::STS_OK;
                state      <= S_FIN;
              end
            endcase
          end
        end
        S_ROW: begin
          row_in   <= span.in_span;
          row_edge <= span.edge_hit;
          col      <= '0;
          state    <= S_PIX;
        end
        S_PIX: begin
          if (col_last) begin
            if (row_last) begin
              state <= S_FIN;
            end else begin
              row      <= row + rcr_pkg::IDX_W'(1);
              row_base <= row_base + rcr_pkg::ADDR_W'(rcr_pkg::MAX_DIM);
              state    <= S_ROW;
            end
          end else begin
            col <= col + rcr_pkg::IDX_W'(1);
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            pixel_value <= res_ram ? ram_rdata : '0;
            status      <= res_status;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign draw_zero    = in_xfer && (func == rcr_pkg::FUNC_DRAW) &&
                        (rect_width == '0 || rect_height == '0);
  assign clear_xfer   = in_xfer && (func == rcr_pkg::FUNC_CLEAR);
  assign wr_in_canvas = (rcr_pkg::DIM_W'(col) < eff_w) && (rcr_pkg::DIM_W'(row) < eff_h);

  `RCR_ASSERT_NEXT(a_zero_size_sets_err, draw_zero, err)
  `RCR_ASSERT_NEXT(a_clear_drops_err, clear_xfer, !err)
  `RCR_ASSERT_NOW(a_write_in_canvas, ram_we, wr_in_canvas)
  `RCR_ASSERT_NEXT(a_fin_loads_result, state == S_FIN && out_free, out_valid && state == S_IDLE)

endmodule

### dv/rectangle_canvas_rasterizer_unit_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_canvas_rasterizer_unit_check
// watches the operation, result and register channels, keeps its own copy of
// the canvas and the registers, and compares every returned result field by
// field with the reply predicted for the oldest outstanding operation
// ----------------------------------------------------------------------------
module rectangle_canvas_rasterizer_unit_check (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [1:0]                        func,
  input  logic signed [rcr_pkg::POS_W-1:0]  rect_left,
  input  logic signed [rcr_pkg::POS_W-1:0]  rect_top,
  input  logic [rcr_pkg::SIZE_W-1:0]        rect_width,
  input  logic [rcr_pkg::SIZE_W-1:0]        rect_height,
  input  logic                              filled,
  input  logic [rcr_pkg::BYTE_W-1:0]        paint_byte,
  input  logic [7:0]                        pixel_col,
  input  logic [7:0]                        pixel_row,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [rcr_pkg::BYTE_W-1:0]        pixel_value,
  input  logic [1:0]                        status,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [rcr_pkg::CFG_W-1:0]         cfg_data,
  output int                                mismatches,
  output int                                unanswered
);
  import rcr_pkg::*;

  localparam longint ONE_UNIT = longint'(1) << FRAC_BITS;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel;
    logic [1:0]        code;
  } canvas_reply_t;

  logic [BYTE_W-1:0] canvas_mem [0:DEPTH-1];
  logic              rect_fault;
  logic [CFG_W-1:0]  cols_cfg;
  logic [CFG_W-1:0]  rows_cfg;
  logic [BYTE_W-1:0] fill_byte;
  canvas_reply_t     canvas_replies [$];

  initial begin
    for (int i = 0; i < DEPTH; i++) canvas_mem[i] = '0;
  end

  function automatic int clamp_span(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // applies the operation on the input ports to the canvas copy
  function automatic canvas_reply_t canvas_apply();
    canvas_reply_t reply;
    int ncols, nrows, r, c;
    longint x_lo, y_lo, x_hi, y_hi, px, py;
    logic edge_px;
    ncols = clamp_span(cols_cfg);
    nrows = clamp_span(rows_cfg);
    reply.pixel = '0;
    reply.code = rect_fault ? STS_ERR : STS_OK;
    case (func)
      FUNC_CLEAR: begin
        for (r = 0; r < nrows; r++)
          for (c = 0; c < ncols; c++) canvas_mem[r * MAX_DIM + c] = fill_byte;
        rect_fault = 1'b0;
        reply.code = STS_OK;
      end
      FUNC_DRAW: begin
        if (rect_width == '0 || rect_height == '0) rect_fault = 1'b1;
        if (rect_fault) begin
          reply.code = STS_ERR;
        end else begin
          x_lo = longint'(rect_left);
          y_lo = longint'(rect_top);
          x_hi = x_lo + longint'(rect_width);
          y_hi = y_lo + longint'(rect_height);
          for (r = 0; r < nrows; r++) begin
            py = longint'(r) * ONE_UNIT;
            if (py < y_lo || py > y_hi) continue;
            for (c = 0; c < ncols; c++) begin
              px = longint'(c) * ONE_UNIT;
              if (px < x_lo || px > x_hi) continue;
              edge_px = (px - x_lo < ONE_UNIT) || (x_hi - px < ONE_UNIT) ||
                        (py - y_lo < ONE_UNIT) || (y_hi - py < ONE_UNIT);
              if (edge_px || filled) canvas_mem[r * MAX_DIM + c] = paint_byte;
            end
          end
          reply.code = STS_OK;
        end
      end
      FUNC_READ: begin
        if (int'(pixel_col) >= ncols || int'(pixel_row) >= nrows) begin
          reply.code = STS_RANGE;
        end else begin
          reply.pixel = canvas_mem[int'(pixel_row) * MAX_DIM + int'(pixel_col)];
        end
      end
      default: ;
    endcase
    return reply;
  endfunction

  task automatic flag_miss(input string field_name, input int want_v, input int got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s expected %0d, got %0d", $time, field_name, want_v, got_v);
  endtask

  always @(posedge clk) begin : watch
    canvas_reply_t want;
    if (rst) begin
      cols_cfg = DIM_RESET;
      rows_cfg = DIM_RESET;
      fill_byte = BG_RESET;
      rect_fault = 1'b0;
      mismatches = 0;
      canvas_replies.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WIDTH:  cols_cfg = cfg_data;
          CFG_HEIGHT: rows_cfg = cfg_data;
          CFG_BG:     fill_byte = cfg_data[BYTE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (canvas_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no operation outstanding, pixel_value %0d status %0d",
                     $time, pixel_value, status);
        end else begin
          want = canvas_replies.pop_front();
          if (pixel_value !== want.pixel) flag_miss("pixel_value", want.pixel, pixel_value);
          if (status !== want.code) flag_miss("status", want.code, status);
        end
      end
      if (in_valid && in_ready) canvas_replies.push_back(canvas_apply());
    end
    unanswered = canvas_replies.size();
  end

endmodule

### dv/rectangle_canvas_rasterizer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_canvas_rasterizer_unit_tb
// drives clear, draw, read and unused operations through the canvas unit over
// a series of canvas sizes and backgrounds, with directed corner cases first,
// then random traffic under several idle and stall patterns; a side checker
// predicts and compares every result
// ----------------------------------------------------------------------------
module rectangle_canvas_rasterizer_unit_tb;
  import rcr_pkg::*;

  localparam int         QUIET_LIMIT = 250000;
  localparam int         HOLD_CYCLES = 400;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               func;
  logic signed [POS_W-1:0]  rect_left;
  logic signed [POS_W-1:0]  rect_top;
  logic [SIZE_W-1:0]        rect_width;
  logic [SIZE_W-1:0]        rect_height;
  logic                     filled;
  logic [BYTE_W-1:0]        paint_byte;
  logic [7:0]               pixel_col;
  logic [7:0]               pixel_row;
  logic                     out_valid;
  logic                     out_ready;
  logic [BYTE_W-1:0]        pixel_value;
  logic [1:0]               status;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [1:0]               cfg_index;
  logic [CFG_W-1:0]         cfg_data;

  int mismatches;
  int unanswered;
  int sent_ops;
  int done_ops;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  int n_clear = 0;
  int n_draw = 0;
  int n_read = 0;
  int n_other = 0;
  int n_settings = 0;

  rectangle_canvas_rasterizer_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .rect_left(rect_left), .rect_top(rect_top),
    .rect_width(rect_width), .rect_height(rect_height), .filled(filled),
    .paint_byte(paint_byte), .pixel_col(pixel_col), .pixel_row(pixel_row),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_value(pixel_value), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rectangle_canvas_rasterizer_unit_check u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .rect_left(rect_left), .rect_top(rect_top),
    .rect_width(rect_width), .rect_height(rect_height), .filled(filled),
    .paint_byte(paint_byte), .pixel_col(pixel_col), .pixel_row(pixel_row),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_value(pixel_value), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .unanswered(unanswered)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      sent_ops <= 0;
      done_ops <= 0;
    end else begin
      if (in_valid && in_ready) sent_ops <= sent_ops + 1;
      if (out_valid && out_ready) done_ops <= done_ops + 1;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int hold_left;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  function automatic int rnd();
    return int'($urandom);
  endfunction

  task automatic send_op(input logic [1:0] f, input int l, t, w, h, fl, pb, c, r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    func <= f;
    rect_left <= POS_W'(l);
    rect_top <= POS_W'(t);
    rect_width <= SIZE_W'(w);
    rect_height <= SIZE_W'(h);
    filled <= fl[0];
    paint_byte <= BYTE_W'(pb);
    pixel_col <= 8'(c);
    pixel_row <= 8'(r);
    do @(posedge clk); while (!in_ready);
    case (f)
      FUNC_CLEAR: n_clear++;
      FUNC_DRAW:  n_draw++;
      FUNC_READ:  n_read++;
      default:    n_other++;
    endcase
  endtask

  task automatic do_clear();
    send_op(FUNC_CLEAR, rnd(), rnd(), rnd(), rnd(), rnd(), rnd(), rnd(), rnd());
  endtask

  task automatic do_draw(input int l, t, w, h, fl, pb);
    send_op(FUNC_DRAW, l, t, w, h, fl, pb, rnd(), rnd());
  endtask

  task automatic do_read(input int c, r);
    send_op(FUNC_READ, rnd(), rnd(), rnd(), rnd(), rnd(), rnd(), c, r);
  endtask

  task automatic do_unused();
    send_op(FUNC_UNUSED, rnd(), rnd(), rnd(), rnd(), rnd(), rnd(), rnd(), rnd());
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sent_ops != done_ops);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_canvas(input int cols, rows, bg);
    drain();
    write_reg(CFG_WIDTH, CFG_W'(cols));
    write_reg(CFG_HEIGHT, CFG_W'(rows));
    write_reg(CFG_BG, CFG_W'(bg & 255));
    n_settings++;
  endtask

  task automatic random_op(input int cw, ch);
    int pick;
    int l, t, w, h, c, r;
    pick = $urandom_range(0, 99);
    l = int'($urandom_range(0, (cw + 4) * 256)) - 512;
    t = int'($urandom_range(0, (ch + 4) * 256)) - 512;
    w = int'($urandom_range(0, (cw + 2) * 256));
    h = int'($urandom_range(0, (ch + 2) * 256));
    if ($urandom_range(0, 9) == 0) begin
      l = rnd();
      t = rnd();
      w = rnd();
      h = rnd();
    end
    if ($urandom_range(0, 15) == 0) begin
      if ($urandom_range(0, 1)) w = 0;
      else h = 0;
    end
    c = int'($urandom_range(0, (cw < 255) ? cw + 1 : 255));
    r = int'($urandom_range(0, (ch < 255) ? ch + 1 : 255));
    if ($urandom_range(0, 7) == 0) c = int'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) r = int'($urandom_range(0, 255));
    if (pick < 10) do_clear();
    else if (pick < 50) do_draw(l, t, w, h, rnd(), rnd());
    else if (pick < 95) do_read(c, r);
    else send_op(FUNC_UNUSED, l, t, w, h, rnd(), rnd(), c, r);
  endtask

  task automatic run_phase(input int cols, rows, bg, idle_pct, stall_pct, count);
    int cw, ch;
    set_canvas(cols, rows, bg);
    cw = (cols == 0) ? 1 : ((cols > MAX_DIM) ? MAX_DIM : cols);
    ch = (rows == 0) ? 1 : ((rows > MAX_DIM) ? MAX_DIM : rows);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    do_clear();
    repeat (count) random_op(cw, ch);
    drain();
  endtask

  initial begin : stimulus
    rst <= 1'b1;
    in_valid <= 1'b0;
    func <= FUNC_CLEAR;
    rect_left <= '0;
    rect_top <= '0;
    rect_width <= '0;
    rect_height <= '0;
    filled <= 1'b0;
    paint_byte <= '0;
    pixel_col <= '0;
    pixel_row <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_WIDTH;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset-size canvas: draw before any clear, then one full clear
    do_draw(0, 0, 512, 512, 1, int'("R"));
    do_clear();
    do_read(255, 255);

    set_canvas(8, 6, int'("."));
    do_clear();
    // outline only
    do_draw(256, 256, 1024, 768, 0, int'("r"));
    do_read(1, 1);
    do_read(2, 2);
    do_read(5, 4);
    // fractional corner partly off the canvas
    do_draw(-128, 640, 832, 256, 1, 255);
    do_read(0, 3);
    do_read(2, 3);
    // extreme fields
    do_draw(-8388608, 8388607, 8388607, 8388607, 1, 0);
    do_draw(0, 0, 8388607, 8388607, 0, 0);
    do_read(0, 5);
    // reads off the canvas and an unused code
    do_read(8, 0);
    do_read(255, 255);
    do_unused();
    // zero width sets the sticky error, later draws are ignored
    do_draw(256, 256, 0, 512, 1, int'("x"));
    do_draw(256, 256, 512, 512, 1, int'("y"));
    do_read(3, 3);
    do_unused();
    do_clear();
    do_read(3, 3);

    // long result hold-off while reads keep coming
    hold_req = 1'b1;
    repeat (6) do_read(int'($urandom_range(0, 7)), int'($urandom_range(0, 5)));
    drain();

    run_phase(12, 9, 46, 0, 0, 10);
    run_phase(0, 1, 0, 78, 0, 8);
    run_phase(511, 3, 255, 0, 78, 8);
    run_phase(3, 511, 90, 37, 37, 8);
    run_phase(16, 16, 165, 78, 0, 10);
    run_phase(int'($urandom_range(1, 24)), int'($urandom_range(1, 24)), rnd(), 0, 78, 10);
    run_phase(7, 20, 35, 37, 37, 10);

    repeat (64) @(posedge clk);
    $display("ran %0d clears, %0d draws, %0d reads and %0d unused codes",
             n_clear, n_draw, n_read, n_other);
    $display("over %0d canvas settings, with idle, stall and long hold-off patterns",
             n_settings + 1);
    if (mismatches == 0 && unanswered == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
